// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent assertions of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/ilhr_pkg.sv -----
// ----------------------------------------------------------------------------
// ilhr_pkg
// Types, widths, register codes and the CORDIC angle table of the turn-rate unit.
// ----------------------------------------------------------------------------
package ilhr_pkg;

	localparam int POSITION_BITS = 20;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int WARMUP_TICKS_DEF = 3;
	localparam int CORDIC_TABLE_LEN = 24;

	localparam int HEADING_W = 16;
	localparam int ANGLE_W = 32;
	localparam int TURN_W = 32;
	localparam int RATE_W = 10;
	localparam int OFFSET_W = 10;
	localparam int GAIN_W = 16;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 4;
	localparam int REG_IDX_W = 2;

	// Datapath widths.
	localparam int DX_W = POSITION_BITS + 1;
	localparam int VX_W = POSITION_BITS + 12;
	localparam int E_W = POSITION_BITS + 10;
	localparam int U_W = POSITION_BITS + 29;
	localparam int MPLIER_W = 32;
	localparam int MUL_CNT_W = $clog2(MPLIER_W);
	localparam int PROD_W = U_W + MPLIER_W;
	localparam int NUM_W = POSITION_BITS + 32;

	// Last multiplier bit index for each operand kind.
	localparam logic [MUL_CNT_W-1:0] MUL_LAST_SHORT = MUL_CNT_W'(RATE_W);
	localparam logic [MUL_CNT_W-1:0] MUL_LAST_GAIN = MUL_CNT_W'(GAIN_W);
	localparam logic [MUL_CNT_W-1:0] MUL_LAST_Q30 = MUL_CNT_W'(MPLIER_W - 1);

	localparam logic signed [ANGLE_W-1:0] CORDIC_INIT_X = 32'sd652032874;

	localparam logic [REG_IDX_W-1:0] REG_RATE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAIN = 2'd2;

	localparam logic [RATE_W-1:0] RATE_RST = 10'd100;
	localparam logic [OFFSET_W-1:0] OFFSET_RST = 10'd220;
	localparam logic [GAIN_W-1:0] GAIN_RST = 16'd384;

	typedef struct packed {
		logic signed [POSITION_BITS-1:0] current_x;
		logic signed [POSITION_BITS-1:0] current_y;
		logic [HEADING_W-1:0] heading;
		logic signed [POSITION_BITS-1:0] target_x;
		logic signed [POSITION_BITS-1:0] target_y;
	} pose_t;

	typedef struct packed {
		logic signed [TURN_W-1:0] turn_rate;
		logic ready_res;
	} turn_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_MUL_VX,
		ST_MUL_VY,
		ST_MUL_BC,
		ST_MUL_BS,
		ST_MUL_GE1,
		ST_MUL_GE2,
		ST_MUL_US,
		ST_MUL_UC,
		ST_DIV,
		ST_OUT
	} state_t;

	// Arctangent of 2^-i as a fraction of a turn, 2^32 per turn.
	function automatic logic signed [ANGLE_W-1:0] atan_turn(input logic [4:0] idx);
		logic signed [ANGLE_W-1:0] v;
		case (idx)
			5'd0: v = 32'sh20000000;
			5'd1: v = 32'sh12E4051E;
			5'd2: v = 32'sh09FB385B;
			5'd3: v = 32'sh051111D4;
			5'd4: v = 32'sh028B0D43;
			5'd5: v = 32'sh0145D7E1;
			5'd6: v = 32'sh00A2F61E;
			5'd7: v = 32'sh00517C55;
			5'd8: v = 32'sh0028BE53;
			5'd9: v = 32'sh00145F2F;
			5'd10: v = 32'sh000A2F98;
			5'd11: v = 32'sh000517CC;
			5'd12: v = 32'sh00028BE6;
			5'd13: v = 32'sh000145F3;
			5'd14: v = 32'sh0000A2FA;
			5'd15: v = 32'sh0000517D;
			5'd16: v = 32'sh000028BE;
			5'd17: v = 32'sh0000145F;
			5'd18: v = 32'sh00000A30;
			5'd19: v = 32'sh00000518;
			5'd20: v = 32'sh0000028C;
			5'd21: v = 32'sh00000146;
			5'd22: v = 32'sh000000A3;
			5'd23: v = 32'sh00000051;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- hw/rtl/ilhr_cordic.sv -----
// ----------------------------------------------------------------------------
// ilhr_cordic
// Iterative CORDIC rotator giving sine and cosine of a binary heading, Q2.30.
// ----------------------------------------------------------------------------
module ilhr_cordic #(
	parameter int CORDIC_STEPS = ilhr_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [ilhr_pkg::HEADING_W-1:0] heading,
	output logic done,
	output logic signed [ilhr_pkg::ANGLE_W-1:0] sin_val,
	output logic signed [ilhr_pkg::ANGLE_W-1:0] cos_val
);
	import ilhr_pkg::*;

	localparam int IDX_W = $clog2(CORDIC_STEPS);

	logic signed [ANGLE_W-1:0] x_q, y_q, z_q;
	logic signed [ANGLE_W-1:0] dx, dy, at;
	logic [ANGLE_W-1:0] angle;
	logic [IDX_W-1:0] idx_q;
	logic flip_q, busy_q, done_q;

	assign angle = {heading, 16'h0000};
	assign dx = y_q >>> idx_q;
	assign dy = x_q >>> idx_q;
	assign at = atan_turn(5'(idx_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (busy_q) begin
				if (idx_q == IDX_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// Fold the angle into [-90, 90) degrees; the result is negated later.
			flip_q <= angle[31] ^ angle[30];
			z_q <= (angle[31] ^ angle[30]) ? {~angle[31], angle[30:0]} : angle;
			x_q <= CORDIC_INIT_X;
			y_q <= '0;
		end else if (busy_q) begin
			if (!z_q[ANGLE_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
	assign cos_val = flip_q ? -x_q : x_q;
	assign sin_val = flip_q ? -y_q : y_q;

endmodule

// ----- hw/rtl/ilhr_mul.sv -----
// ----------------------------------------------------------------------------
// ilhr_mul
// Radix-2 shift-add signed multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ilhr_mul (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [ilhr_pkg::U_W-1:0] mcand,
	input  logic signed [ilhr_pkg::MPLIER_W-1:0] mplier,
	input  logic [ilhr_pkg::MUL_CNT_W-1:0] last,
	output logic done,
	output logic signed [ilhr_pkg::PROD_W-1:0] prod
);
	import ilhr_pkg::*;

	logic signed [PROD_W-1:0] acc_q, mc_q, term, sum;
	logic [MPLIER_W-1:0] mp_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic busy_q, done_q;

	// The top multiplier bit carries negative weight.
	always_comb begin
		term = mp_q[0] ? mc_q : '0;
		sum = (cnt_q == '0) ? acc_q - term : acc_q + term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= last;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q <= PROD_W'(mcand);
			mp_q <= mplier;
		end else if (busy_q) begin
			acc_q <= sum;
			mc_q <= mc_q <<< 1;
			mp_q <= mp_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ----- hw/rtl/ilhr_div.sv -----
// ----------------------------------------------------------------------------
// ilhr_div
// Restoring divider by the point offset, truncating, saturated to 32 bits.
// ----------------------------------------------------------------------------
module ilhr_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [ilhr_pkg::NUM_W-1:0] dividend,
	input  logic [ilhr_pkg::OFFSET_W-1:0] divisor,
	output logic done,
	output logic signed [ilhr_pkg::TURN_W-1:0] quot
);
	import ilhr_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] q_q;
	logic [OFFSET_W-1:0] rem_q;
	logic [OFFSET_W:0] trial, diff;
	logic [CNT_W-1:0] cnt_q;
	logic neg_q, busy_q, done_q, fits;
	logic big_pos, big_neg;

	assign trial = {rem_q, q_q[NUM_W-1]};
	assign diff = trial - {1'b0, divisor};
	assign fits = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[NUM_W-1];
			q_q <= dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[OFFSET_W-1:0] : trial[OFFSET_W-1:0];
			q_q <= {q_q[NUM_W-2:0], fits};
		end
	end

	always_comb begin
		big_pos = |q_q[NUM_W-1:TURN_W-1];
		big_neg = (|q_q[NUM_W-1:TURN_W]) || (q_q[TURN_W-1] && (|q_q[TURN_W-2:0]));
		if (neg_q) begin
			quot = big_neg ? {1'b1, {(TURN_W-1){1'b0}}} : -$signed(q_q[TURN_W-1:0]);
		end else begin
			quot = big_pos ? {1'b0, {(TURN_W-1){1'b1}}} : $signed(q_q[TURN_W-1:0]);
		end
	end

	assign done = done_q;

endmodule

// ----- hw/rtl/io_linearization_heading_rate_unit.sv -----
// ----------------------------------------------------------------------------
// io_linearization_heading_rate_unit
// Sequence: an item during warm-up gives its zero result in the cycle after it is
// accepted; a full item runs the CORDIC loop, then the chain of products on the
// bit-serial multiplier and then the bit-serial divider before its result is offered.
// Throughput: one item at a time; a new item is taken after the result leaves.
// Reset: arst_n clears the sequencer, the warm-up count and the stored target
// and loads the register defaults; no item is pending after reset.
// ----------------------------------------------------------------------------
module io_linearization_heading_rate_unit #(
	parameter int CORDIC_STEPS = ilhr_pkg::CORDIC_STEPS_DEF,
	parameter int WARMUP_TICKS = ilhr_pkg::WARMUP_TICKS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ilhr_pkg::ADDR_W-1:0] paddr,
	input  logic [ilhr_pkg::DATA_W-1:0] pwdata,
	output logic [ilhr_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input  logic pose_valid,
	output logic pose_ready,
	input  ilhr_pkg::pose_t pose,
	output logic turn_valid,
	input  logic turn_ready,
	output ilhr_pkg::turn_t turn
);
	import ilhr_pkg::*;

	// Configuration registers.
	logic [RATE_W-1:0] rate_q;
	logic [OFFSET_W-1:0] offset_q, b_eff;
	logic [GAIN_W-1:0] gain_q;
	logic [REG_IDX_W-1:0] reg_idx;

	// Per-tick state kept between items.
	logic signed [POSITION_BITS-1:0] prev_x_q, prev_y_q;
	logic [1:0] warm_q, warm_next;
	logic warm_ok;

	// Sequencer.
	state_t state_q, state_next;
	logic issued_q;
	logic cordic_start, mul_start, div_start;
	logic cordic_done, mul_done, div_done;

	// Datapath registers of the item in flight.
	pose_t pose_q;
	turn_t turn_q;
	logic signed [DX_W-1:0] dx_q, dy_q;
	logic signed [VX_W-1:0] vx_q, vy_q;
	logic signed [ANGLE_W-1:0] sin_q, cos_q, sin_w, cos_w;
	logic signed [E_W-1:0] e1_q, e2_q, errx, erry, off_sh;
	logic signed [U_W-1:0] u1_q, u2_q;
	logic signed [NUM_W-1:0] m1_q, num_q, prod_q30;
	logic signed [TURN_W-1:0] div_quot;

	// Shared multiplier operands.
	logic signed [U_W-1:0] mcand;
	logic signed [MPLIER_W-1:0] mplier;
	logic [MUL_CNT_W-1:0] mul_last;
	logic signed [PROD_W-1:0] mul_prod;

	// ------------------------------------------------------------------
	// Configuration port. Writes complete in the access phase; pready is
	// tied high, so no wait states are ever inserted.
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RST;
			offset_q <= OFFSET_RST;
			gain_q <= GAIN_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_RATE: rate_q <= pwdata[RATE_W-1:0];
				REG_OFFSET: offset_q <= pwdata[OFFSET_W-1:0];
				REG_GAIN: gain_q <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RATE: prdata = DATA_W'(rate_q);
			REG_OFFSET: prdata = DATA_W'(offset_q);
			REG_GAIN: prdata = DATA_W'(gain_q);
			default: prdata = '0;
		endcase
	end

	// A zero offset is treated as one millimetre so the divide is defined.
	assign b_eff = (offset_q == '0) ? OFFSET_W'(1) : offset_q;

	// ------------------------------------------------------------------
	// Warm-up. The count saturates at three; an item is live once the
	// count after it reaches WARMUP_TICKS. Items in warm-up skip the
	// arithmetic and give a zero turn rate with ready_res low.
	// ------------------------------------------------------------------
	assign warm_next = (warm_q == 2'd3) ? warm_q : warm_q + 2'd1;
	assign warm_ok = warm_next >= 2'(WARMUP_TICKS);

	// ------------------------------------------------------------------
	// Sequencer. Each compute state issues one operation on its unit,
	// waits for the unit's done pulse and moves on. The issued flag makes
	// the start a single pulse taken from operands already registered.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issued_q <= 1'b0;
			warm_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else begin
			state_q <= state_next;
			if (cordic_start || mul_start || div_start) begin
				issued_q <= 1'b1;
			end else if (cordic_done || mul_done || div_done) begin
				issued_q <= 1'b0;
			end
			if (pose_valid && pose_ready) begin
				warm_q <= warm_next;
				prev_x_q <= pose.target_x;
				prev_y_q <= pose.target_y;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		pose_ready = 1'b0;
		turn_valid = 1'b0;
		cordic_start = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pose_ready = 1'b1;
				if (pose_valid) begin
					state_next = warm_ok ? ST_CORDIC : ST_OUT;
				end
			end
			ST_CORDIC: begin
				cordic_start = !issued_q;
				if (cordic_done) begin
					state_next = ST_MUL_VX;
				end
			end
			ST_MUL_VX: begin
				mul_start = !issued_q;
				if (mul_done) begin
					state_next = ST_MUL_VY;
				end
			end
			ST_MUL_VY: begin
				mul_start = !issued_q;
				if (mul_done) begin
					state_next = ST_MUL_BC;
				end
			end
			ST_MUL_BC: begin
				mul_start = !issued_q;
				if (mul_done) begin
					state_next = ST_MUL_BS;
				end
			end
			ST_MUL_BS: begin
				mul_start = !issued_q;
				if (mul_done) begin
					state_next = ST_MUL_GE1;
				end
			end
			ST_MUL_GE1: begin
				mul_start = !issued_q;
				if (mul_done) begin
					state_next = ST_MUL_GE2;
				end
			end
			ST_MUL_GE2: begin
				mul_start = !issued_q;
				if (mul_done) begin
					state_next = ST_MUL_US;
				end
			end
			ST_MUL_US: begin
				mul_start = !issued_q;
				if (mul_done) begin
					state_next = ST_MUL_UC;
				end
			end
			ST_MUL_UC: begin
				mul_start = !issued_q;
				if (mul_done) begin
					state_next = ST_DIV;
				end
			end
			ST_DIV: begin
				div_start = !issued_q;
				if (div_done) begin
					state_next = ST_OUT;
				end
			end
			ST_OUT: begin
				turn_valid = 1'b1;
				if (turn_ready) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Operand selection for the shared multiplier. Unsigned registers go
	// in as positive signed values one bit wider than themselves.
	// ------------------------------------------------------------------
	always_comb begin
		mcand = U_W'(dx_q);
		mplier = MPLIER_W'($signed({1'b0, rate_q}));
		mul_last = MUL_LAST_SHORT;
		case (state_q)
			ST_MUL_VY: mcand = U_W'(dy_q);
			ST_MUL_BC: begin
				mcand = U_W'(cos_q);
				mplier = MPLIER_W'($signed({1'b0, b_eff}));
			end
			ST_MUL_BS: begin
				mcand = U_W'(sin_q);
				mplier = MPLIER_W'($signed({1'b0, b_eff}));
			end
			ST_MUL_GE1: begin
				mcand = U_W'(e1_q);
				mplier = MPLIER_W'($signed({1'b0, gain_q}));
				mul_last = MUL_LAST_GAIN;
			end
			ST_MUL_GE2: begin
				mcand = U_W'(e2_q);
				mplier = MPLIER_W'($signed({1'b0, gain_q}));
				mul_last = MUL_LAST_GAIN;
			end
			ST_MUL_US: begin
				mcand = u1_q;
				mplier = sin_q;
				mul_last = MUL_LAST_Q30;
			end
			ST_MUL_UC: begin
				mcand = u2_q;
				mplier = cos_q;
				mul_last = MUL_LAST_Q30;
			end
			default: ;
		endcase
	end

	// Position error in Q.8 mm minus the offset point, floored shifts.
	assign errx = E_W'(pose_q.target_x) - E_W'(pose_q.current_x);
	assign erry = E_W'(pose_q.target_y) - E_W'(pose_q.current_y);
	assign off_sh = E_W'(mul_prod >>> 22);
	assign prod_q30 = NUM_W'(mul_prod >>> 30);

	// ------------------------------------------------------------------
	// Datapath capture. Each unit's done pulse writes the value that the
	// current state was waiting for.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (pose_valid && pose_ready) begin
			pose_q <= pose;
			dx_q <= DX_W'(pose.target_x) - DX_W'(prev_x_q);
			dy_q <= DX_W'(pose.target_y) - DX_W'(prev_y_q);
			if (!warm_ok) begin
				turn_q <= '0;
			end
		end
		if (cordic_done) begin
			sin_q <= sin_w;
			cos_q <= cos_w;
		end
		if (mul_done) begin
			case (state_q)
				ST_MUL_VX: vx_q <= VX_W'(mul_prod);
				ST_MUL_VY: vy_q <= VX_W'(mul_prod);
				ST_MUL_BC: e1_q <= (errx <<< 8) - off_sh;
				ST_MUL_BS: e2_q <= (erry <<< 8) - off_sh;
				ST_MUL_GE1: u1_q <= (U_W'(vx_q) <<< 16) + U_W'(mul_prod);
				ST_MUL_GE2: u2_q <= (U_W'(vy_q) <<< 16) + U_W'(mul_prod);
				ST_MUL_US: m1_q <= prod_q30;
				ST_MUL_UC: num_q <= m1_q - prod_q30;
				default: ;
			endcase
		end
		if (div_done) begin
			turn_q.turn_rate <= div_quot;
			turn_q.ready_res <= 1'b1;
		end
	end

	assign turn = turn_q;

	ilhr_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cordic_start),
		.heading(pose_q.heading),
		.done(cordic_done),
		.sin_val(sin_w),
		.cos_val(cos_w)
	);

	ilhr_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.mcand(mcand),
		.mplier(mplier),
		.last(mul_last),
		.done(mul_done),
		.prod(mul_prod)
	);

	ilhr_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(num_q),
		.divisor(b_eff),
		.done(div_done),
		.quot(div_quot)
	);

endmodule

// ----- hw/rtl/ilhr_checker.sv -----
// ----------------------------------------------------------------------------
// ilhr_checker
// Port-level checks of the turn-rate unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ilhr_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic pready,
	input  logic pose_valid,
	input  logic pose_ready,
	input  logic turn_valid,
	input  logic turn_ready,
	input  ilhr_pkg::turn_t turn
);
	import ilhr_pkg::*;

	// One item at a time: no new item is taken while a result waits.
	`ASSERT_ALWAYS(a_one_item, clk, arst_n, !(pose_ready && turn_valid))

	// Taking an item closes the input side on the next cycle.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, pose_valid && pose_ready, !pose_ready)

	// A warm-up result carries a zero turn rate.
	`ASSERT_IMPLY(a_warmup_zero, clk, arst_n, turn_valid && !turn.ready_res, turn.turn_rate == '0)

	// A stalled result holds.
	`ASSERT_NEXT(a_turn_hold, clk, arst_n, turn_valid && !turn_ready, turn_valid && $stable(turn))

	`ASSERT_ALWAYS(a_no_wait, clk, arst_n, pready)

endmodule

bind io_linearization_heading_rate_unit ilhr_checker u_ilhr_checker (.*);
